[hw/rtl/rct_pkg.sv]
// ----------------------------------------------------------------------------
// rct_pkg
// Types and codes shared by the range completion tracker modules.
// ----------------------------------------------------------------------------
package rct_pkg;

  localparam int unsigned SizeBits = 48;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_RECORD = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_BOUNDS  = 2'd1,
    ERR_OVERLAP = 2'd2,
    ERR_MISSING = 2'd3
  } err_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [SizeBits-1:0] offset;
    logic [SizeBits-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          error_code;
    logic [SizeBits-1:0] bytes_done;
    logic                table_full;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SEARCH_WAIT,
    ST_PREV,
    ST_PREV_WAIT,
    ST_MOVE,
    ST_INSERT,
    ST_WALK_WAIT,
    ST_DONE
  } state_t;

  // Which table entry the datapath reads into its read register.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_IDX,    // entry at the index counter
    RD_NEXT,   // entry above the index counter
    RD_PREV,   // entry below the index counter
    RD_PREV2,  // entry two below the index counter
    RD_TOP     // highest stored entry; the counter moves to the entry count
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // latch the item and run the first checks
    rd_sel_t    rd;         // table read
    logic       step_idx;   // index counter up by one
    logic       dec_idx;    // index counter down by one
    logic       wr_shift;   // write the read entry at the index counter
    logic       wr_insert;  // write the new range at the index counter
    logic       do_start;   // clear table and count
    logic       set_err;    // take the error code below
    logic [1:0] err;
    logic       set_full;
    logic       fire;       // present the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       started;
    logic       bad_rec;     // record fails the started, length or bounds check
    logic       idx_at_end;  // index counter equals the entry count
    logic       idx_last;    // index counter is the highest stored entry
    logic       idx_zero;
    logic       idx_one;
    logic       table_full;
    logic       rd_lt_off;   // read begin below the offset
    logic       rd_lt_stop;  // read begin below the end of the new range
    logic       prev_gt_off; // read end above the offset
    logic       rd_ne_exp;   // read begin differs from the expected begin
    logic       tot_zero;
    logic       empty_zero;  // no entries and no bytes
    logic       end_ok;      // read end and byte count match the total
  } stat_t;

endpackage

[hw/rtl/range_completion_tracker.sv]
// ----------------------------------------------------------------------------
// range_completion_tracker
// Byte range arrival tracker with a sorted range table in block memory.
// ----------------------------------------------------------------------------
//   channel   handshake               payload
//   command   start / busy            cmd_in  (action, offset, length)
//   result    done (one cycle)        result  (error_code, bytes_done, full)
//   config    total_size_we           total_size_wdata
//
// Busy stays high from the accepting edge until the command is through; a record
// or a finish takes longer as more ranges are stored, since the range memory gives
// one read and one write per cycle. The done strobe comes in the same cycle that
// busy falls; a new command can be taken in that cycle. Reset clears the counters;
// the memory needs no clearing. The result cannot be stalled.
// ----------------------------------------------------------------------------
module range_completion_tracker #(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  rct_pkg::in_item_t         cmd_in,
  output logic                      done,
  output rct_pkg::out_item_t        result,
  input  logic                      total_size_we,
  input  logic [rct_pkg::SizeBits-1:0] total_size_wdata
);

  logic [rct_pkg::SizeBits-1:0] total_size;
  rct_pkg::cmd_t                cmd;
  rct_pkg::stat_t               stat;
  logic [1:0]                   res_err;
  logic [rct_pkg::SizeBits-1:0] res_bytes;
  logic                         res_full;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) total_size <= '0;
    else if (total_size_we) total_size <= total_size_wdata;
  end

  rct_control u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  rct_datapath #(
    .MAX_RANGES(MAX_RANGES),
    .SIZE_BITS (rct_pkg::SizeBits)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .total_size(total_size),
    .in_action (cmd_in.action),
    .in_offset (cmd_in.offset),
    .in_length (cmd_in.length),
    .cmd       (cmd),
    .stat      (stat),
    .res_err   (res_err),
    .res_bytes (res_bytes),
    .res_full  (res_full)
  );

  // Result transfer.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.fire;
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      result.error_code <= res_err;
      result.bytes_done <= res_bytes;
      result.table_full <= res_full;
    end
  end

endmodule

[hw/rtl/rct_datapath.sv]
// ----------------------------------------------------------------------------
// rct_datapath
// Range table memory, index counter, byte count and comparators.
// ----------------------------------------------------------------------------
module rct_datapath #(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned SIZE_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SIZE_BITS-1:0] total_size,
  input  logic [1:0]           in_action,
  input  logic [SIZE_BITS-1:0] in_offset,
  input  logic [SIZE_BITS-1:0] in_length,
  input  rct_pkg::cmd_t        cmd,
  output rct_pkg::stat_t       stat,
  output logic [1:0]           res_err,
  output logic [SIZE_BITS-1:0] res_bytes,
  output logic                 res_full
);

  localparam int unsigned IdxBits = $clog2(MAX_RANGES);
  localparam int unsigned CntBits = $clog2(MAX_RANGES + 1);

  logic [SIZE_BITS-1:0] mem_begin [MAX_RANGES];
  logic [SIZE_BITS-1:0] mem_end   [MAX_RANGES];
  logic [SIZE_BITS-1:0] rd_begin;
  logic [SIZE_BITS-1:0] rd_end;

  logic                 started;
  logic [CntBits-1:0]   count;
  logic [SIZE_BITS-1:0] bytes;
  logic [CntBits-1:0]   idx;
  logic [1:0]           action;
  logic [SIZE_BITS-1:0] offset;
  logic [SIZE_BITS-1:0] length;
  logic [SIZE_BITS-1:0] stop;
  logic [SIZE_BITS-1:0] expect_pos;
  logic                 bad;
  logic [1:0]           err;
  logic                 full;
  logic [IdxBits-1:0]   rd_addr;

  // Record checks that come straight from the item and the register.
  logic bad_now;
  assign bad_now = !started || (in_length == '0) || (in_offset > total_size) ||
                   (in_length > (total_size - in_offset));

  // Read address for the entry the controller asks for.
  always_comb begin
    case (cmd.rd)
      rct_pkg::RD_NEXT:  rd_addr = IdxBits'(idx + CntBits'(1));
      rct_pkg::RD_PREV:  rd_addr = IdxBits'(idx - CntBits'(1));
      rct_pkg::RD_PREV2: rd_addr = IdxBits'(idx - CntBits'(2));
      rct_pkg::RD_TOP:   rd_addr = IdxBits'(count - CntBits'(1));
      default:           rd_addr = idx[IdxBits-1:0];
    endcase
  end

  // Memory read and write ports.
  always_ff @(posedge clk) begin
    if (cmd.rd != rct_pkg::RD_NONE) begin
      rd_begin <= mem_begin[rd_addr];
      rd_end   <= mem_end[rd_addr];
    end
    if (cmd.wr_shift) begin
      mem_begin[idx[IdxBits-1:0]] <= rd_begin;
      mem_end[idx[IdxBits-1:0]]   <= rd_end;
    end else if (cmd.wr_insert) begin
      mem_begin[idx[IdxBits-1:0]] <= offset;
      mem_end[idx[IdxBits-1:0]]   <= stop;
    end
  end

  // Item latch and walk pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action     <= in_action;
      offset     <= in_offset;
      length     <= in_length;
      stop       <= in_offset + in_length;
      bad        <= bad_now;
      expect_pos <= '0;
    end else if (cmd.step_idx) begin
      expect_pos <= rd_end;
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      count   <= '0;
      bytes   <= '0;
      idx     <= '0;
      err     <= rct_pkg::ERR_NONE;
      full    <= 1'b0;
    end else begin
      if (cmd.load) begin
        err <= rct_pkg::ERR_NONE;
      end else if (cmd.set_err) begin
        err <= cmd.err;
      end
      if (cmd.load) begin
        full <= 1'b0;
      end else if (cmd.set_full) begin
        full <= 1'b1;
      end
      // Shifting starts at the top: the counter moves to the entry count.
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.rd == rct_pkg::RD_TOP) begin
        idx <= count;
      end else if (cmd.dec_idx) begin
        idx <= idx - CntBits'(1);
      end else if (cmd.step_idx) begin
        idx <= idx + CntBits'(1);
      end
      if (cmd.do_start) begin
        started <= 1'b1;
        count   <= '0;
        bytes   <= '0;
      end else if (cmd.wr_insert) begin
        count <= count + CntBits'(1);
        bytes <= bytes + length;
      end
    end
  end

  assign stat.action      = action;
  assign stat.started     = started;
  assign stat.bad_rec     = bad;
  assign stat.idx_at_end  = (idx == count);
  assign stat.idx_last    = ((idx + CntBits'(1)) == count);
  assign stat.idx_zero    = (idx == '0);
  assign stat.idx_one     = (idx == CntBits'(1));
  assign stat.table_full  = (count == CntBits'(MAX_RANGES));
  assign stat.rd_lt_off   = (rd_begin < offset);
  assign stat.rd_lt_stop  = (rd_begin < stop);
  assign stat.prev_gt_off = (rd_end > offset);
  assign stat.rd_ne_exp   = (rd_begin != expect_pos);
  assign stat.tot_zero    = (total_size == '0);
  assign stat.empty_zero  = (count == '0) && (bytes == '0);
  assign stat.end_ok      = (rd_end == total_size) && (bytes == total_size);

  assign res_err   = err;
  assign res_bytes = bytes;
  assign res_full  = full;

endmodule

[hw/rtl/rct_control.sv]
// ----------------------------------------------------------------------------
// rct_control
// Sequencer for start, record (search, shift, insert) and finish walk.
// ----------------------------------------------------------------------------
module rct_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rct_pkg::stat_t stat,
  output rct_pkg::cmd_t  cmd
);

  rct_pkg::state_t state;
  rct_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rct_pkg::ST_IDLE: begin
        if (start) state_next = rct_pkg::ST_SEARCH;
      end
      rct_pkg::ST_SEARCH: begin
        // First cycle after load: dispatch on the action.
        case (stat.action)
          rct_pkg::ACT_RECORD: begin
            if (stat.bad_rec) state_next = rct_pkg::ST_DONE;
            else if (stat.idx_at_end) state_next = rct_pkg::ST_PREV;
            else state_next = rct_pkg::ST_SEARCH_WAIT;
          end
          rct_pkg::ACT_FINISH: begin
            if (!stat.started || stat.tot_zero || stat.idx_at_end) begin
              state_next = rct_pkg::ST_DONE;
            end else begin
              state_next = rct_pkg::ST_WALK_WAIT;
            end
          end
          default: state_next = rct_pkg::ST_DONE;
        endcase
      end
      rct_pkg::ST_SEARCH_WAIT: begin
        // Entry at the index is in the read register.
        if (stat.rd_lt_off) begin
          if (stat.idx_last) state_next = rct_pkg::ST_PREV;
        end else if (stat.rd_lt_stop) begin
          state_next = rct_pkg::ST_DONE;
        end else begin
          state_next = rct_pkg::ST_PREV;
        end
      end
      rct_pkg::ST_PREV: begin
        // The index is the insert position; check the entry below it.
        if (!stat.idx_zero) state_next = rct_pkg::ST_PREV_WAIT;
        else if (stat.table_full || stat.idx_at_end) state_next = rct_pkg::ST_DONE;
        else state_next = rct_pkg::ST_MOVE;
      end
      rct_pkg::ST_PREV_WAIT: begin
        if (stat.prev_gt_off || stat.table_full) state_next = rct_pkg::ST_DONE;
        else state_next = rct_pkg::ST_MOVE;
      end
      rct_pkg::ST_MOVE: begin
        // Move entries up one place until the one below starts before offset.
        if (stat.rd_lt_off) state_next = rct_pkg::ST_DONE;
        else if (stat.idx_one) state_next = rct_pkg::ST_INSERT;
      end
      rct_pkg::ST_INSERT: state_next = rct_pkg::ST_DONE;
      rct_pkg::ST_WALK_WAIT: begin
        if (stat.rd_ne_exp || stat.idx_last) state_next = rct_pkg::ST_DONE;
      end
      rct_pkg::ST_DONE: state_next = rct_pkg::ST_IDLE;
      default: state_next = rct_pkg::ST_IDLE;
    endcase
  end

  // Outputs. The record path runs a search pass upward to find the insert
  // position, then a shift pass downward from the top entry.
  always_comb begin
    cmd     = '0;
    cmd.err = rct_pkg::ERR_NONE;
    busy    = (state != rct_pkg::ST_IDLE);
    case (state)
      rct_pkg::ST_IDLE: cmd.load = start;
      rct_pkg::ST_SEARCH: begin
        case (stat.action)
          rct_pkg::ACT_START: cmd.do_start = 1'b1;
          rct_pkg::ACT_RECORD: begin
            if (stat.bad_rec) begin
              cmd.set_err = 1'b1;
              cmd.err     = rct_pkg::ERR_BOUNDS;
            end else if (!stat.idx_at_end) begin
              cmd.rd = rct_pkg::RD_IDX;
            end
          end
          rct_pkg::ACT_FINISH: begin
            if (!stat.started) begin
              cmd.set_err = 1'b1;
              cmd.err     = rct_pkg::ERR_MISSING;
            end else if (stat.tot_zero) begin
              cmd.set_err = !stat.empty_zero;
              cmd.err     = rct_pkg::ERR_BOUNDS;
            end else if (stat.idx_at_end) begin
              // Empty table cannot cover a nonzero total.
              cmd.set_err = 1'b1;
              cmd.err     = rct_pkg::ERR_MISSING;
            end else begin
              cmd.rd = rct_pkg::RD_IDX;
            end
          end
          default: ;
        endcase
      end
      rct_pkg::ST_SEARCH_WAIT: begin
        if (stat.rd_lt_off) begin
          cmd.step_idx = 1'b1;
          if (!stat.idx_last) cmd.rd = rct_pkg::RD_NEXT;
        end else if (stat.rd_lt_stop) begin
          cmd.set_err = 1'b1;
          cmd.err     = rct_pkg::ERR_OVERLAP;
        end
      end
      rct_pkg::ST_PREV: begin
        if (!stat.idx_zero) begin
          cmd.rd = rct_pkg::RD_PREV;
        end else if (stat.table_full) begin
          cmd.set_full = 1'b1;
        end else if (stat.idx_at_end) begin
          cmd.wr_insert = 1'b1;
        end else begin
          cmd.rd = rct_pkg::RD_TOP;
        end
      end
      rct_pkg::ST_PREV_WAIT: begin
        if (stat.prev_gt_off) begin
          cmd.set_err = 1'b1;
          cmd.err     = rct_pkg::ERR_OVERLAP;
        end else if (stat.table_full) begin
          cmd.set_full = 1'b1;
        end else begin
          cmd.rd = rct_pkg::RD_TOP;
        end
      end
      rct_pkg::ST_MOVE: begin
        if (stat.rd_lt_off) begin
          cmd.wr_insert = 1'b1;
        end else begin
          cmd.wr_shift = 1'b1;
          cmd.dec_idx  = 1'b1;
          if (!stat.idx_one) cmd.rd = rct_pkg::RD_PREV2;
        end
      end
      rct_pkg::ST_INSERT: cmd.wr_insert = 1'b1;
      rct_pkg::ST_WALK_WAIT: begin
        if (stat.rd_ne_exp) begin
          cmd.set_err = 1'b1;
          cmd.err     = rct_pkg::ERR_MISSING;
        end else if (stat.idx_last) begin
          cmd.set_err = !stat.end_ok;
          cmd.err     = rct_pkg::ERR_MISSING;
        end else begin
          cmd.step_idx = 1'b1;
          cmd.rd       = rct_pkg::RD_NEXT;
        end
      end
      rct_pkg::ST_DONE: cmd.fire = 1'b1;
      default: ;
    endcase
  end

endmodule

[hw/rtl/rct_checker.sv]
// ----------------------------------------------------------------------------
// rct_checker
// Port-level checks for the range completion tracker.
// ----------------------------------------------------------------------------
module rct_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input rct_pkg::out_item_t       result
);

  // An accepted item makes the block busy.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("not busy after accepted item");

  // A result comes only while an item is in flight.
  a_done_needs_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without item");

  // Results are single-cycle pulses.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result held longer than a cycle");

  // A full table is never reported together with an error.
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.table_full |-> result.error_code == rct_pkg::ERR_NONE)
    else $error("full flag with error");

endmodule

bind range_completion_tracker rct_checker u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

[tb/tb_range_completion_tracker.sv]
// ----------------------------------------------------------------------------
// tb_range_completion_tracker
// Self-checking bench for the range completion tracker. Commands go through
// the start/busy handshake with random gaps. Each command's result is
// predicted by a software copy of the sorted range table and compared field
// by field with the one-cycle done strobe. The total size is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_range_completion_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Width = rct_pkg::SizeBits;
  localparam int unsigned Depth = 64;
  localparam int unsigned Limit = 3000000;
  localparam logic [Width-1:0] MaxVal = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  rct_pkg::in_item_t cmd_in = '0;
  logic done;
  rct_pkg::out_item_t result;
  logic total_size_we = 1'b0;
  logic [Width-1:0] total_size_wdata = '0;

  range_completion_tracker #(.MAX_RANGES(Depth)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd_in(cmd_in),
    .done(done), .result(result), .total_size_we(total_size_we),
    .total_size_wdata(total_size_wdata)
  );

  // Shadow copy of the tracker state.
  logic [Width-1:0] shadow_total;
  logic             shadow_started;
  int unsigned      shadow_count;
  logic [Width-1:0] shadow_begin [Depth];
  logic [Width-1:0] shadow_end [Depth];
  logic [Width-1:0] shadow_bytes;

  rct_pkg::in_item_t  pending_cmds[$];
  rct_pkg::out_item_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cmds_sent = 0;
  int unsigned full_hits = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  logic idle_hold = 1'b1;

  // Record one range into the shadow table and return the expected result.
  function automatic rct_pkg::out_item_t track_record(logic [Width-1:0] off,
                                                     logic [Width-1:0] len);
    rct_pkg::out_item_t r;
    int unsigned pos;
    logic [Width-1:0] stop;
    r = '0;
    pos = 0;
    stop = off + len;
    r.error_code = rct_pkg::ERR_NONE;
    if (!shadow_started || len == 0 || off > shadow_total || len > shadow_total - off) begin
      r.error_code = rct_pkg::ERR_BOUNDS;
    end else begin
      while (pos < shadow_count && shadow_begin[pos] < off) pos++;
      if ((pos > 0 && shadow_end[pos-1] > off) ||
          (pos < shadow_count && shadow_begin[pos] < stop)) begin
        r.error_code = rct_pkg::ERR_OVERLAP;
      end else if (shadow_count >= Depth) begin
        r.table_full = 1'b1;
      end else begin
        for (int unsigned k = shadow_count; k > pos; k--) begin
          shadow_begin[k] = shadow_begin[k-1];
          shadow_end[k] = shadow_end[k-1];
        end
        shadow_begin[pos] = off;
        shadow_end[pos] = stop;
        shadow_count++;
        shadow_bytes = shadow_bytes + len;
      end
    end
    r.bytes_done = shadow_bytes;
    return r;
  endfunction

  // Check contiguous coverage of the shadow table.
  function automatic rct_pkg::err_t track_finish();
    logic [Width-1:0] nxt;
    nxt = '0;
    if (!shadow_started) return rct_pkg::ERR_MISSING;
    if (shadow_total == 0)
      return (shadow_count != 0 || shadow_bytes != 0) ? rct_pkg::ERR_BOUNDS
                                                      : rct_pkg::ERR_NONE;
    for (int unsigned k = 0; k < shadow_count; k++) begin
      if (shadow_begin[k] != nxt) return rct_pkg::ERR_MISSING;
      nxt = shadow_end[k];
    end
    if (nxt != shadow_total || shadow_bytes != shadow_total) return rct_pkg::ERR_MISSING;
    return rct_pkg::ERR_NONE;
  endfunction

  function automatic rct_pkg::out_item_t track_command(rct_pkg::in_item_t c);
    rct_pkg::out_item_t r;
    r = '0;
    case (rct_pkg::action_t'(c.action))
      rct_pkg::ACT_START: begin
        shadow_started = 1'b1;
        shadow_count = 0;
        shadow_bytes = '0;
      end
      rct_pkg::ACT_RECORD: r = track_record(c.offset, c.length);
      rct_pkg::ACT_FINISH: r.error_code = track_finish();
      default: ;
    endcase
    if (c.action != rct_pkg::ACT_RECORD) r.bytes_done = shadow_bytes;
    return r;
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  // Driver: one transfer per accepted command, random gap before each.
  always @(posedge clk) begin
    if (rst || idle_hold) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      cmds_sent <= cmds_sent + 1;
      expected_results.push_back(track_command(cmd_in));
      if (expected_results[$].table_full) full_hits <= full_hits + 1;
      start <= 1'b0;
      gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() > 0) begin
        cmd_in <= pending_cmds.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: compare each strobe with the oldest expectation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", result);
      end else begin
        rct_pkg::out_item_t e;
        e = expected_results.pop_front();
        if (e.error_code !== result.error_code || e.bytes_done !== result.bytes_done ||
            e.table_full !== result.table_full) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected err=%0d bytes=%0d full=%0b, got err=%0d bytes=%0d full=%0b",
                     e.error_code, e.bytes_done, e.table_full,
                     result.error_code, result.bytes_done, result.table_full);
        end
      end
    end
    if (cycle_count > Limit) begin
      $display("tb_range_completion_tracker NOT OK");
      $finish;
    end
  end

  function automatic rct_pkg::in_item_t mk(rct_pkg::action_t a, logic [Width-1:0] off,
                                           logic [Width-1:0] len);
    rct_pkg::in_item_t c;
    c.action = a;
    c.offset = off;
    c.length = len;
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_total(logic [Width-1:0] v);
    total_size_wdata <= v;
    total_size_we <= 1'b1;
    @(posedge clk);
    total_size_we <= 1'b0;
    shadow_total = v;
    @(posedge clk);
  endtask

  // A transfer: start, split the total into pieces, send them shuffled,
  // occasionally drop or duplicate one or add a random record, then finish.
  task automatic queue_transfer(int unsigned pieces, logic [Width-1:0] tot);
    logic [Width-1:0] cuts[$];
    rct_pkg::in_item_t recs[$];
    logic [Width-1:0] lo;
    int unsigned sel;
    lo = '0;
    pending_cmds.push_back(mk(rct_pkg::ACT_START, Width'({$urandom, $urandom}),
                              Width'({$urandom, $urandom})));
    for (int unsigned i = 1; i < pieces; i++)
      cuts.push_back(Width'((64'(tot) * i) / pieces));
    cuts.push_back(tot);
    foreach (cuts[i]) begin
      if (cuts[i] > lo) recs.push_back(mk(rct_pkg::ACT_RECORD, lo, cuts[i] - lo));
      lo = cuts[i];
    end
    recs.shuffle();
    if (recs.size() > 1 && $urandom_range(0, 5) == 0) void'(recs.pop_back());
    if (recs.size() > 0 && $urandom_range(0, 5) == 0) begin
      sel = $urandom_range(0, recs.size() - 1);
      recs.insert($urandom_range(0, recs.size()), recs[sel]);
    end
    foreach (recs[i]) pending_cmds.push_back(recs[i]);
    if ($urandom_range(0, 4) == 0)
      pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, Width'({$urandom, $urandom}),
                                Width'({$urandom, $urandom})));
    pending_cmds.push_back(mk(rct_pkg::ACT_FINISH, '0, '0));
  endtask

  initial begin
    logic [Width-1:0] tot;
    int unsigned queued;
    shadow_total = '0;
    shadow_started = 1'b0;
    shadow_count = 0;
    shadow_bytes = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_hold <= 1'b0;

    // Directed: commands before start, zero total, bounds, overlap, no-op.
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, '0, 48'd1));
    pending_cmds.push_back(mk(rct_pkg::ACT_FINISH, '0, '0));
    pending_cmds.push_back(mk(rct_pkg::ACT_START, '0, '0));
    pending_cmds.push_back(mk(rct_pkg::ACT_FINISH, '0, '0));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, '0, 48'd1));
    pending_cmds.push_back(mk(rct_pkg::ACT_NOP, MaxVal, MaxVal));
    wait_drained();
    set_total(48'd100);
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, 48'd10, '0));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, 48'd50, 48'd51));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, 48'd101, 48'd1));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, MaxVal, MaxVal));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, 48'd40, 48'd20));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, 48'd30, 48'd11));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, 48'd59, 48'd5));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, 48'd45, 48'd2));
    pending_cmds.push_back(mk(rct_pkg::ACT_FINISH, '0, '0));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, 48'd0, 48'd40));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, 48'd60, 48'd40));
    pending_cmds.push_back(mk(rct_pkg::ACT_FINISH, '0, '0));
    wait_drained();
    set_total(MaxVal);
    pending_cmds.push_back(mk(rct_pkg::ACT_START, '0, '0));
    pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, '0, MaxVal));
    pending_cmds.push_back(mk(rct_pkg::ACT_FINISH, '0, '0));
    wait_drained();

    // Table overflow: fill all entries with unit ranges, then two more.
    set_total(48'd200);
    pending_cmds.push_back(mk(rct_pkg::ACT_START, '0, '0));
    for (int unsigned i = 0; i < Depth + 2; i++)
      pending_cmds.push_back(mk(rct_pkg::ACT_RECORD, Width'(2 * i), 48'd1));
    pending_cmds.push_back(mk(rct_pkg::ACT_FINISH, '0, '0));
    wait_drained();

    // Random phases with a new total each time.
    queued = 0;
    while (queued < 1525) begin
      case ($urandom_range(0, 5))
        0: tot = Width'({$urandom, $urandom});
        1: tot = MaxVal;
        2: tot = '0;
        default: tot = Width'($urandom_range(1, 5000));
      endcase
      set_total(tot);
      for (int unsigned t = 0; t < 6; t++) begin
        if ($urandom_range(0, 4) == 0) begin
          for (int unsigned n = 0; n < 8; n++) begin
            rct_pkg::in_item_t c;
            c.action = 2'($urandom);
            c.offset = Width'({$urandom, $urandom});
            c.length = Width'({$urandom, $urandom});
            if ($urandom_range(0, 1)) c.length = Width'($urandom_range(0, 300));
            if ($urandom_range(0, 1)) c.offset = Width'($urandom_range(0, 300));
            pending_cmds.push_back(c);
          end
          queued += 8;
        end else begin
          int unsigned p;
          p = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
          queue_transfer(p, tot);
          queued += p + 2;
        end
      end
      wait_drained();
    end

    $display("Sent %0d commands and checked %0d results, %0d refused by a full table.",
             cmds_sent, results_seen, full_hits);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_range_completion_tracker OK");
    end else begin
      $display("tb_range_completion_tracker NOT OK");
    end
    $finish;
  end
endmodule
